[sv/nsr_pkg.sv]
// shared constants, types and codes of the newton square root block
`timescale 1ns / 1ps

package nsr_pkg;

  // fixed point format of the radicand and the estimate
  localparam int FracBits  = 16;
  localparam int DataWidth = 32;

  // field and register widths
  localparam int RootW   = 32;
  localparam int StatusW = 2;
  localparam int StepsW  = 6;
  localparam int ThrW    = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 32;

  // datapath widths
  localparam int QuoW  = DataWidth + FracBits;       // quotient of (x << FracBits) / g
  localparam int SqW   = 2 * DataWidth - FracBits;   // truncated square of g
  localparam int ProdW = 2 * DataWidth;
  localparam int CntW  = $clog2(QuoW);

  // reset values of the configuration registers
  localparam logic [ThrW-1:0]   ThrReset     = ThrW'(66);
  localparam logic [StepsW-1:0] MaxIterReset = StepsW'(32);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgMaxIter   = 2'd1
  } nsr_cfg_idx_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatNeg   = 2'd1,
    StatLimit = 2'd2
  } nsr_status_e;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StClass,
    StSquare,
    StError,
    StCheck,
    StDivide,
    StUpdate,
    StDone
  } nsr_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic        load;
    logic        square;
    logic        error;
    logic        div_init;
    logic        div_step;
    logic        update;
    logic        finish;
    nsr_status_e fin_status;
  } nsr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_neg;
    logic is_trivial;
    logic err_below;
    logic at_limit;
    logic g_zero;
    logic div_last;
    logic out_busy;
  } nsr_flags_t;

endpackage

[sv/nsr_datapath.sv]
// datapath of the newton square root: estimate, square, error, divider, result register
`timescale 1ns / 1ps

module nsr_datapath import nsr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nsr_cmd_t                    cmd_i,
  output nsr_flags_t                  flags_o,
  input  logic signed [DataWidth-1:0] radicand_i,
  input  logic                        cfg_valid_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [RootW-1:0]            root_o,
  output logic [StatusW-1:0]          status_o,
  output logic [StepsW-1:0]           steps_o
);

  localparam logic [DataWidth-1:0] One    = DataWidth'(1) << FracBits;
  localparam logic [DataWidth-1:0] TwoOne = DataWidth'(2) << FracBits;
  localparam logic [CntW-1:0]      CntLast = CntW'(QuoW - 1);

  logic [ThrW-1:0]      thr_q;
  logic [StepsW-1:0]    max_iter_q;
  logic [DataWidth-1:0] x_q, g_q, g_d;
  logic [SqW-1:0]       sq_q, err_q;
  logic [QuoW-1:0]      quo_q, dvd_q;
  logic [DataWidth-1:0] rem_q;
  logic [CntW-1:0]      cnt_q;
  logic [StepsW-1:0]    steps_q;
  logic                 out_valid_q;
  logic [RootW-1:0]     root_q;
  logic [StatusW-1:0]   status_q;
  logic [StepsW-1:0]    steps_out_q;

  logic [DataWidth-1:0] x_in, g_init;
  logic [ProdW-1:0]     prod;
  logic [SqW-1:0]       x_ext;
  logic [DataWidth:0]   rem_sh;
  logic                 rem_ge;
  logic [QuoW:0]        g_sum;

  // configuration registers, always ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= ThrReset;
      max_iter_q <= MaxIterReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgThreshold: thr_q      <= cfg_data_i[ThrW-1:0];
        CfgMaxIter:   max_iter_q <= cfg_data_i[StepsW-1:0];
        default: ;
      endcase
    end
  end

  // start estimate: zero for negatives, 1.0 below 2.0, x/2 above, the radicand itself for zero and one
  always_comb begin
    x_in = radicand_i;
    if (x_in[DataWidth-1]) begin
      g_init = '0;
    end else if (x_in == '0) begin
      g_init = '0;
    end else if (x_in < TwoOne) begin
      g_init = One;
    end else begin
      g_init = x_in >> 1;
    end
  end

  // squaring and error terms
  assign prod  = ProdW'(g_q) * ProdW'(g_q);
  assign x_ext = SqW'(x_q);

  // one restoring division step
  assign rem_sh = {rem_q, dvd_q[QuoW-1]};
  assign rem_ge = rem_sh >= {1'b0, g_q};

  // averaged estimate, clamped to the data width
  always_comb begin
    g_sum = (QuoW+1)'(quo_q >> 1) + (QuoW+1)'(g_q >> 1)
          + (QuoW+1)'(quo_q[0] & g_q[0]);
    if (g_sum[QuoW:DataWidth] != '0) begin
      g_d = '1;
    end else begin
      g_d = g_sum[DataWidth-1:0];
    end
  end

  // iteration registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_in;
      g_q     <= g_init;
      steps_q <= '0;
    end
    if (cmd_i.square) begin
      sq_q <= prod[ProdW-1:FracBits];
    end
    if (cmd_i.error) begin
      err_q <= (sq_q >= x_ext) ? sq_q - x_ext : x_ext - sq_q;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      dvd_q <= {x_q, FracBits'(0)};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DataWidth'(rem_sh - {1'b0, g_q}) : rem_sh[DataWidth-1:0];
      quo_q <= {quo_q[QuoW-2:0], rem_ge};
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.update) begin
      g_q     <= g_d;
      steps_q <= steps_q + StepsW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      root_q      <= RootW'(g_q);
      status_q    <= cmd_i.fin_status;
      steps_out_q <= steps_q;
    end
  end

  // status toward the controller
  always_comb begin
    flags_o.is_neg     = x_q[DataWidth-1];
    flags_o.is_trivial = (x_q == '0) || (x_q == One);
    flags_o.err_below  = err_q < SqW'(thr_q);
    flags_o.at_limit   = steps_q >= max_iter_q;
    flags_o.g_zero     = (g_q == '0);
    flags_o.div_last   = (cnt_q == CntLast);
    flags_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign status_o    = status_q;
  assign steps_o     = steps_out_q;

endmodule

[sv/nsr_ctrl.sv]
// controller state machine of the newton square root
`timescale 1ns / 1ps

module nsr_ctrl import nsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nsr_flags_t flags_i,
  output nsr_cmd_t   cmd_o
);

  nsr_state_e  state_q, state_d;
  nsr_status_e stat_q, stat_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stat_q  <= StatOk;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    stat_d         = stat_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.fin_status = stat_q;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StClass;
        end
      end
      StClass: begin
        if (flags_i.is_neg) begin
          stat_d  = StatNeg;
          state_d = StDone;
        end else if (flags_i.is_trivial) begin
          stat_d  = StatOk;
          state_d = StDone;
        end else begin
          state_d = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StError;
      end
      StError: begin
        cmd_o.error = 1'b1;
        state_d     = StCheck;
      end
      StCheck: begin
        if (flags_i.err_below) begin
          stat_d  = StatOk;
          state_d = StDone;
        end else if (flags_i.at_limit || flags_i.g_zero) begin
          stat_d  = StatLimit;
          state_d = StDone;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = StDivide;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (flags_i.div_last) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StSquare;
      end
      StDone: begin
        if (!flags_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

[sv/newton_square_root.sv]
// top level of the newton square root of a signed q16.16 radicand
//
// usage: one radicand beat on the in channel (valid/ready) gives one result
// beat on the out channel: root (unsigned q16.16), status and step count.
// the cfg channel writes threshold (index 0) and max_iterations (index 1);
// it is always ready; the user must write it only while the block is idle,
// and the block itself has no check for this. negative, zero and one
// radicands go from classify straight to done; other radicands run n
// newton steps, each step being square, error, check, a bit-serial
// restoring divider and an update. the divider sets the rate.
// one item is worked on at a time; a new radicand is taken while the
// previous result still waits in the output register.
// a stalled receiver holds the result beat; a finished item then waits in
// its last state until the output register frees.
// reset clears the controller and output valid and restores threshold 66
// and max_iterations 32.
`timescale 1ns / 1ps

module newton_square_root import nsr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DataWidth-1:0] radicand_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [RootW-1:0]            root_o,
  output logic [StatusW-1:0]          status_o,
  output logic [StepsW-1:0]           steps_o
);

  nsr_cmd_t   cmd;
  nsr_flags_t flags;

  assign cfg_ready_o = 1'b1;

  // controller
  nsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // datapath
  nsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .radicand_i  (radicand_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .root_o      (root_o),
    .status_o    (status_o),
    .steps_o     (steps_o)
  );

endmodule

[tb/nsr_checker.sv]
// result checker of the newton square root block: watches channels, predicts and compares
`timescale 1ns / 1ps

module nsr_checker import nsr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic signed [DataWidth-1:0] radicand_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [RootW-1:0]            root_i,
  input  logic [StatusW-1:0]          status_i,
  input  logic [StepsW-1:0]           steps_i,
  output int                          errors_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [RootW-1:0]  root;
    nsr_status_e       status;
    logic [StepsW-1:0] steps;
  } root_result_t;

  // local copy of the configuration registers
  logic [ThrW-1:0]   threshold_q;
  logic [StepsW-1:0] step_cap_q;

  root_result_t root_expect_q[$];
  int           mismatch_count = 0;
  int           pending_count  = 0;
  int           result_beats   = 0;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;

  // newton iteration on the unsigned radicand, start at 1.0 below 2.0 and at x/2 above
  function automatic root_result_t predict_root(logic [DataWidth-1:0] raw,
                                                logic [ThrW-1:0] thr,
                                                logic [StepsW-1:0] cap);
    root_result_t res;
    logic [63:0]  x;
    logic [63:0]  g;
    logic [63:0]  sq;
    logic [63:0]  err;
    logic [63:0]  quo;
    logic [127:0] prod;
    logic [63:0]  one;
    int           n;
    logic         searching;
    res = '0;
    one = 64'd1 << FracBits;
    x   = 64'(raw);
    if (raw[DataWidth-1]) begin
      res.status = StatNeg;
      return res;
    end
    if (x == 64'd0 || x == one) begin
      res.root   = RootW'(x);
      res.status = StatOk;
      return res;
    end
    g = (x < 2 * one) ? one : (x >> 1);
    n = 0;
    searching = 1'b1;
    while (searching) begin
      // truncated square, saturated beyond 64 bits
      prod = {64'd0, g} * {64'd0, g};
      if ((prod[127:64] >> FracBits) != 64'd0) sq = '1;
      else sq = prod[FracBits +: 64];
      err = (sq >= x) ? sq - x : x - sq;
      if (err < 64'(thr)) begin
        res.status = StatOk;
        searching  = 1'b0;
      end else if (n >= int'(cap) || g == 64'd0) begin
        res.status = StatLimit;
        searching  = 1'b0;
      end else begin
        quo = (x << FracBits) / g;
        g = (quo >> 1) + (g >> 1) + (quo & g & 64'd1);
        if (g > 64'({DataWidth{1'b1}})) g = 64'({DataWidth{1'b1}});
        n++;
      end
    end
    res.root  = RootW'(g);
    res.steps = StepsW'(n);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result beat %0d: %s got 0x%0h expected 0x%0h",
             result_beats, what, got, want);
    mismatch_count++;
  endtask

  // track config, queue expectations, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    root_result_t want;
    if (!rst_ni) begin
      threshold_q = ThrReset;
      step_cap_q  = MaxIterReset;
      root_expect_q.delete();
      pending_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (nsr_cfg_idx_e'(cfg_index_i))
          CfgThreshold: threshold_q = cfg_data_i[ThrW-1:0];
          CfgMaxIter:   step_cap_q  = cfg_data_i[StepsW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        root_expect_q.push_back(predict_root(radicand_i, threshold_q, step_cap_q));
      if (out_valid_i && out_ready_i) begin
        if (root_expect_q.size() == 0) begin
          report_mismatch("unexpected beat, root", 64'(root_i), 64'd0);
        end else begin
          want = root_expect_q.pop_front();
          if (root_i !== want.root) report_mismatch("root", 64'(root_i), 64'(want.root));
          if (status_i !== want.status)
            report_mismatch("status", 64'(status_i), 64'(want.status));
          if (steps_i !== want.steps) report_mismatch("steps", 64'(steps_i), 64'(want.steps));
        end
        result_beats++;
      end
      pending_count = root_expect_q.size();
    end
  end

endmodule

[tb/tb_newton_square_root.sv]
// top of the newton square root testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_newton_square_root;
  import nsr_pkg::*;

  // unused register slots, writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  // run length bounds: worst item is 63 steps plus gap and stalls
  localparam int TotalItems = 1600;
  localparam int MaxGap     = 800;
  localparam int LongHold   = 4000;
  localparam int ItemCycles = 6 + 52 * 63 + MaxGap + 64;
  localparam int CycleLimit = 4 * TotalItems * ItemCycles + 2 * LongHold + 10000;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic signed [DataWidth-1:0] radicand    = '0;
  logic                        cfg_valid   = 1'b0;
  logic                        cfg_ready;
  logic [CfgIdxW-1:0]          cfg_index   = CfgThreshold;
  logic [CfgW-1:0]             cfg_data    = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  logic [RootW-1:0]            root;
  logic [StatusW-1:0]          status;
  logic [StepsW-1:0]           steps;

  int errors;
  int pending;
  int sent_count  = 0;
  int cycle_count = 0;

  newton_square_root DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .radicand_i  (radicand),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .root_o      (root),
    .status_o    (status),
    .steps_o     (steps)
  );

  nsr_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .radicand_i  (radicand),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .root_i      (root),
    .status_i    (status),
    .steps_i     (steps),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // one radicand beat, called and returning at a falling edge
  task automatic send_radicand(logic [DataWidth-1:0] value);
    in_valid <= 1'b1;
    radicand <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // one register write beat, valid left high for a following beat
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every result is out
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // set both registers, with junk above the step cap field
  task automatic configure(logic [ThrW-1:0] thr, logic [StepsW-1:0] cap);
    drain();
    write_cfg(CfgThreshold, thr);
    write_cfg(CfgMaxIter, ($urandom() & ~CfgW'({StepsW{1'b1}})) | CfgW'(cap));
    cfg_valid <= 1'b0;
  endtask

  // radicand mix: full range, below two, near one and two, squares, large
  function automatic logic [DataWidth-1:0] rand_radicand();
    logic [DataWidth-1:0] v;
    int                   k;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3, 4:    v = $urandom_range(0, 32'h0001FFFF);
      5: begin
        v = ($urandom_range(0, 1) != 0) ? 32'h00010000 : 32'h00020000;
        v = v + $urandom_range(0, 64) - 32;
      end
      6, 7:    v = $urandom_range(0, 32'h00FFFFFF);
      8: begin
        k = $urandom_range(0, 181);
        v = DataWidth'(k * k) << FracBits;
      end
      default: v = $urandom() & 32'h7FFFFFFF;
    endcase
    return v;
  endfunction

  // random beats in bursts with random gaps, sometimes long ones
  task automatic send_random(int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        send_radicand(rand_radicand());
        burst--;
        left--;
      end
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(0, MaxGap);
      else gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // receiver: stall patterns of its own, plus long hold-offs to back up the block
  initial begin
    int mode;
    int span;
    int hold_cnt;
    int hold_idx;
    int hold_at[2];
    hold_at[0] = 40;
    hold_at[1] = 900;
    hold_idx   = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 300);
      repeat (span) begin
        @(negedge clk);
        if (hold_idx < 2 && sent_count >= hold_at[hold_idx]) begin
          out_ready <= 1'b0;
          hold_cnt = 0;
          while (hold_cnt < LongHold) begin
            @(negedge clk);
            hold_cnt++;
          end
          hold_idx++;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // main stimulus
  initial begin
    logic [DataWidth-1:0] edge_vals[16];
    logic [DataWidth-1:0] cap_vals[4];
    edge_vals = '{32'h00000000, 32'h00010000, 32'h7FFFFFFF, 32'h80000000,
                  32'hFFFFFFFF, 32'h00000001, 32'h0000FFFF, 32'h00010001,
                  32'h0001FFFF, 32'h00020000, 32'h00020001, 32'h00040000,
                  32'h40000000, 32'h55555555, 32'hAAAAAAAA, 32'h00000002};
    cap_vals  = '{32'h00040000, 32'h00090000, 32'h00008000, 32'h00010000};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset config: field extremes and fixed points
    foreach (edge_vals[i]) send_radicand(edge_vals[i]);
    send_random(350);

    // zero step cap: start value returned, close or not
    configure(ThrReset, 6'd0);
    foreach (cap_vals[i]) send_radicand(cap_vals[i]);
    configure(32'd0, 6'd0);
    foreach (cap_vals[i]) send_radicand(cap_vals[i]);
    send_random(30);

    // zero threshold never accepts, then widest, random and zero thresholds at cap 63
    configure(32'd0, 6'd1);
    send_random(100);
    configure(32'hFFFFFFFF, 6'd63);
    send_random(200);
    configure(ThrW'($urandom_range(0, 4095)), 6'd63);
    send_random(350);
    configure(32'd0, 6'd63);
    send_random(15);

    // random settings
    configure($urandom() >> $urandom_range(0, 31), StepsW'($urandom_range(1, 63)));
    send_random(150);
    configure($urandom() >> $urandom_range(0, 31), StepsW'($urandom_range(1, 63)));
    send_random(150);

    // spare slots must not disturb the registers
    drain();
    write_cfg(CfgSpareA, $urandom());
    write_cfg(CfgSpareB, $urandom());
    cfg_valid <= 1'b0;
    configure(ThrReset, MaxIterReset);
    send_random(150);

    // wind down
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
